// ===== rtl/core/qam_hard_demapper_assert.svh =====
// ---------------------------------------------------------------------------
// qam_hard_demapper assertion macros
// Shared concurrent assertion forms, clocked on the given clock with active-low reset.
// ---------------------------------------------------------------------------
`ifndef QAM_HARD_DEMAPPER_ASSERT_SVH
`define QAM_HARD_DEMAPPER_ASSERT_SVH

// same-cycle implication
`define QAMHD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QAMHD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/qamhd_pkg.sv =====
// ---------------------------------------------------------------------------
// qamhd_pkg
// Shared constants, mode codes and mode decode for the QAM hard demapper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qamhd_pkg;

    localparam int SampleWidthDefault = 16;
    localparam int FracBitsDefault    = 12;

    localparam int NormFrac  = 14;
    localparam int NormWidth = 17;
    localparam int LevelWidth = 4;
    localparam int RowWidth   = 3;
    localparam int CodeWidth  = 6;
    localparam int CountWidth = 3;
    localparam int ModeWidth  = 2;

    // unsigned Q3.14 norms
    localparam logic [NormWidth-1:0] NormQpsk  = 17'd23170;
    localparam logic [NormWidth-1:0] NormQam16 = 17'd51811;
    localparam logic [NormWidth-1:0] NormQam64 = 17'd106180;

    localparam logic [ModeWidth-1:0] MOD_QPSK  = 2'd0;
    localparam logic [ModeWidth-1:0] MOD_QAM16 = 2'd1;
    localparam logic [ModeWidth-1:0] MOD_QAM64 = 2'd2;

    typedef struct packed {
        logic [NormWidth-1:0]  norm;
        logic [RowWidth-1:0]   cap;    // side / 2
        logic [CountWidth-1:0] bits;
        logic [1:0]            shift;  // log2(side)
    } mode_cfg_t;

    function automatic mode_cfg_t decode_mode(input logic [ModeWidth-1:0] mode);
        mode_cfg_t cfg;
        unique case (mode)
            MOD_QPSK: begin
                cfg.norm  = NormQpsk;
                cfg.cap   = 3'd1;
                cfg.bits  = 3'd2;
                cfg.shift = 2'd1;
            end
            MOD_QAM16: begin
                cfg.norm  = NormQam16;
                cfg.cap   = 3'd2;
                cfg.bits  = 3'd4;
                cfg.shift = 2'd2;
            end
            default: begin  // 64-QAM, unused code saturates to it
                cfg.norm  = NormQam64;
                cfg.cap   = 3'd4;
                cfg.bits  = 3'd6;
                cfg.shift = 2'd3;
            end
        endcase
        return cfg;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qamhd_slicer.sv =====
// ---------------------------------------------------------------------------
// qamhd_slicer
// One axis: scale by the mode norm, floor to FRAC_BITS, slice to odd level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qamhd_slicer #(
    parameter int SAMPLE_WIDTH = qamhd_pkg::SampleWidthDefault,
    parameter int FRAC_BITS    = qamhd_pkg::FracBitsDefault
) (
    input  wire logic [SAMPLE_WIDTH-1:0]           sample,
    input  wire qamhd_pkg::mode_cfg_t              mode_cfg,
    output logic signed [qamhd_pkg::LevelWidth-1:0] level,
    output logic [qamhd_pkg::RowWidth-1:0]          row
);

    localparam int PW = SAMPLE_WIDTH + qamhd_pkg::NormWidth;
    localparam int AW = PW + 1 - qamhd_pkg::NormFrac;
    localparam int CW = (AW > FRAC_BITS + 3) ? AW : FRAC_BITS + 3;
    localparam logic [CW-1:0] Th1 = CW'(1) << (FRAC_BITS + 1);
    localparam logic [CW-1:0] Th2 = Th1 << 1;
    localparam logic [CW-1:0] Th3 = Th1 + Th2;
    localparam logic [PW:0]   CeilBias = (PW+1)'((1 << qamhd_pkg::NormFrac) - 1);

    logic                                  neg;
    logic [SAMPLE_WIDTH-1:0]               mag;
    logic [PW-1:0]                         product;
    logic [PW:0]                           biased;
    logic [AW-1:0]                         amag;
    logic [CW-1:0]                         amag_x;
    logic [qamhd_pkg::RowWidth-1:0]        m_raw;
    logic [qamhd_pkg::RowWidth-1:0]        m_sel;
    logic                                  neg_eff;
    logic [qamhd_pkg::LevelWidth-1:0]      lvl_mag;

    assign neg     = sample[SAMPLE_WIDTH-1];
    assign mag     = neg ? (~sample + 1'b1) : sample;
    assign product = PW'(mag) * PW'(mode_cfg.norm);
    // negative side floors toward minus infinity: ceiling of the magnitude
    assign biased  = {1'b0, product} + (neg ? CeilBias : '0);
    assign amag    = biased[PW:qamhd_pkg::NormFrac];
    assign amag_x  = CW'(amag);
    assign neg_eff = neg && (amag != '0);

    always_comb begin
        if (amag_x <= Th1) begin
            m_raw = 3'd1;
        end else if (amag_x <= Th2) begin
            m_raw = 3'd2;
        end else if (amag_x <= Th3) begin
            m_raw = 3'd3;
        end else begin
            m_raw = 3'd4;
        end
        m_sel = (m_raw > mode_cfg.cap) ? mode_cfg.cap : m_raw;
    end

    assign lvl_mag = {m_sel, 1'b0} - 4'd1;
    assign level   = neg_eff ? -lvl_mag : lvl_mag;
    assign row     = neg_eff ? (mode_cfg.cap - m_sel) : (mode_cfg.cap + m_sel - 3'd1);

endmodule

`default_nettype wire

// ===== rtl/core/qam_hard_demapper.sv =====
// ---------------------------------------------------------------------------
// qam_hard_demapper
// Hard-decision demapper for QPSK, 16-QAM and 64-QAM I/Q samples.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake             Payload
// cfg       in   cfg_valid/cfg_ready   cfg_data (modulation)
// s_        in   s_valid/s_ready       s_i_sample, s_q_sample
// m_        out  m_valid/m_ready       m_code_word, m_bit_count, m_i_level, m_q_level
//
// One item per cycle while m_ready allows; items pass the input register, then the result register.
// The per-axis multiply and slice sit between the two registers.
// Stalls on m_ready back up through the input register; s_ready stays high
// while either register is free. cfg_ready is always high.
// Synchronous active-low reset clears the valid flags and the mode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "qam_hard_demapper_assert.svh"

module qam_hard_demapper #(
    parameter int SAMPLE_WIDTH = qamhd_pkg::SampleWidthDefault,
    parameter int FRAC_BITS    = qamhd_pkg::FracBitsDefault
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [qamhd_pkg::ModeWidth-1:0]       cfg_data,

    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]        s_i_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0]        s_q_sample,

    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [qamhd_pkg::CodeWidth-1:0]            m_code_word,
    output logic [qamhd_pkg::CountWidth-1:0]           m_bit_count,
    output logic signed [qamhd_pkg::LevelWidth-1:0]    m_i_level,
    output logic signed [qamhd_pkg::LevelWidth-1:0]    m_q_level
);

    logic [qamhd_pkg::ModeWidth-1:0]         modulation_reg;
    logic                                    in_valid_reg;
    logic [SAMPLE_WIDTH-1:0]                 i_sample_reg;
    logic [SAMPLE_WIDTH-1:0]                 q_sample_reg;
    logic                                    out_valid_reg;
    logic [qamhd_pkg::CodeWidth-1:0]         code_word_reg;
    logic [qamhd_pkg::CountWidth-1:0]        bit_count_reg;
    logic signed [qamhd_pkg::LevelWidth-1:0] i_level_reg;
    logic signed [qamhd_pkg::LevelWidth-1:0] q_level_reg;

    qamhd_pkg::mode_cfg_t                    mode_cfg;
    logic signed [qamhd_pkg::LevelWidth-1:0] i_level_next;
    logic signed [qamhd_pkg::LevelWidth-1:0] q_level_next;
    logic [qamhd_pkg::RowWidth-1:0]          i_row;
    logic [qamhd_pkg::RowWidth-1:0]          q_row;
    logic [qamhd_pkg::CodeWidth-1:0]         code_word_next;
    logic                                    out_advance;
    logic                                    in_accept;

    assign cfg_ready   = 1'b1;
    assign out_advance = !out_valid_reg || m_ready;
    assign s_ready     = !in_valid_reg || out_advance;
    assign in_accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulation_reg <= qamhd_pkg::MOD_QPSK;
        end else if (cfg_valid && cfg_ready) begin
            modulation_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_accept) begin
            in_valid_reg <= 1'b1;
        end else if (out_advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            i_sample_reg <= s_i_sample;
            q_sample_reg <= s_q_sample;
        end
    end

    assign mode_cfg = qamhd_pkg::decode_mode(modulation_reg);

    qamhd_slicer #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_slicer_i (
        .sample   (i_sample_reg),
        .mode_cfg (mode_cfg),
        .level    (i_level_next),
        .row      (i_row)
    );

    qamhd_slicer #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_slicer_q (
        .sample   (q_sample_reg),
        .mode_cfg (mode_cfg),
        .level    (q_level_next),
        .row      (q_row)
    );

    // code = row_i * side + row_q
    assign code_word_next = (qamhd_pkg::CodeWidth'(i_row) << mode_cfg.shift)
                          | qamhd_pkg::CodeWidth'(q_row);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_advance && in_valid_reg) begin
            code_word_reg <= code_word_next;
            bit_count_reg <= mode_cfg.bits;
            i_level_reg   <= i_level_next;
            q_level_reg   <= q_level_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_code_word = code_word_reg;
    assign m_bit_count = bit_count_reg;
    assign m_i_level   = i_level_reg;
    assign m_q_level   = q_level_reg;

    `QAMHD_ASSERT_NOW(a_ready_when_out_free, aclk, aresetn, !out_valid_reg, s_ready, "input stalled with free result register")
    `QAMHD_ASSERT_NEXT(a_item_moves_to_out, aclk, aresetn, in_valid_reg && out_advance, out_valid_reg, "item lost between stages")
    `QAMHD_ASSERT_NOW(a_levels_odd, aclk, aresetn, out_valid_reg, i_level_reg[0] && q_level_reg[0], "decided level not odd")
    `QAMHD_ASSERT_NOW(a_qpsk_code_range, aclk, aresetn, out_valid_reg && (bit_count_reg == 3'd2), code_word_reg[5:2] == 4'd0, "QPSK label out of range")

endmodule

`default_nettype wire
